// ===== hw/rtl/owtr_pkg.sv =====
// Package for the one-wire temperature reader: phase codes, command bytes,
// bus state record and field widths. No dependencies.
package owtr_pkg;

    // Tick counter width; register values beyond its range saturate
    localparam int TICK_W  = 12;
    localparam int CFG_W   = 12;
    localparam int SHORT_W = 8;
    localparam int TENTH_W = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_SHORT     = 3'd0;
    localparam logic [2:0] REG_SLOT      = 3'd1;
    localparam logic [2:0] REG_RST_LOW   = 3'd2;
    localparam logic [2:0] REG_PRES_WAIT = 3'd3;
    localparam logic [2:0] REG_PRES_TAIL = 3'd4;

    // Bus phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_WR_REL   = 4'd6;
    localparam logic [3:0] PH_RD_LOW   = 4'd7;
    localparam logic [3:0] PH_RD_REL   = 4'd8;
    localparam logic [3:0] PH_RD_WAIT  = 4'd9;

    // Operation slots of the sequence
    localparam logic [2:0] OP_RESET_A = 3'd0;
    localparam logic [2:0] OP_RESET_B = 3'd3;
    localparam logic [2:0] OP_READ_LO = 3'd6;
    localparam logic [2:0] OP_READ_HI = 3'd7;

    localparam logic [7:0]  CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0]  CMD_CONVERT   = 8'h44;
    localparam logic [7:0]  CMD_READ_PAD  = 8'hBE;
    localparam logic [15:0] RAW_POS_LIMIT = 16'h0FFF;

    // Full bus state carried from tick to tick
    typedef struct packed {
        logic [3:0]         phase;
        logic [2:0]         op_index;
        logic [2:0]         bit_count;
        logic [TICK_W-1:0]  tick_count;
        logic [7:0]         shift_byte;
        logic [7:0]         low_byte;
        logic [TENTH_W-1:0] held_tenths;
        logic               held_sign;
        logic               held_error;
    } bus_state_t;

    // Byte sent in each write slot of the sequence
    function automatic logic [7:0] cmd_byte(input logic [2:0] op);
        logic [7:0] b;
        case (op)
            3'd1:    b = CMD_SKIP_ROM;
            3'd2:    b = CMD_CONVERT;
            3'd4:    b = CMD_SKIP_ROM;
            3'd5:    b = CMD_READ_PAD;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Counter load for a phase of cfg ticks (zero acts as one tick)
    function automatic logic [TICK_W-1:0] load_ticks(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] n;
        n = (cfg == '0) ? '0 : cfg - CFG_W'(1);
        if (32'(n) > (2 ** TICK_W) - 1)
            return '1;
        return TICK_W'(n);
    endfunction

endpackage

// ===== hw/rtl/one_wire_temperature_reader.sv =====
// One-wire temperature reader top level: tick-driven bus state machine with
// a result register. Depends on owtr_pkg.
//
// Each accepted input transfer is one bus tick carrying a start request and
// the sampled data line; each tick yields exactly one result transfer with
// the line drive, busy/done flags and the held temperature. The block takes
// one tick per clock cycle: the whole bus state update sits between the state
// register and the result register, and a new tick is accepted while the
// previous result waits, as long as the result register is free or being
// drained. A start runs reset/presence, 0xCC 0x44, reset/presence, 0xCC 0xBE
// and two read bytes; the result is the magnitude in tenths of a degree with
// a sign flag, or no_device with zero if presence fails. Slot timing comes
// from five tick-count registers written over the configuration channel,
// which is always ready and should be written only while no sequence runs.
module one_wire_temperature_reader (
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] line_in, [7:2] zero
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [3] no_device, [4] negative,
                                   // [20:5] temp_tenths, [23:21] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    localparam int TW = owtr_pkg::TICK_W;
    localparam int CW = owtr_pkg::CFG_W;

    logic [owtr_pkg::SHORT_W-1:0] short_ticks_reg;
    logic [CW-1:0]                slot_ticks_reg;
    logic [CW-1:0]                rst_low_ticks_reg;
    logic [CW-1:0]                pres_wait_ticks_reg;
    logic [CW-1:0]                pres_tail_ticks_reg;

    owtr_pkg::bus_state_t state_reg, state_next;
    logic        out_valid_reg;
    logic [23:0] out_data_reg, out_data_next;
    logic        in_xfer;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_ticks_reg     <= 8'd2;
            slot_ticks_reg      <= 12'd60;
            rst_low_ticks_reg   <= 12'd480;
            pres_wait_ticks_reg <= 12'd30;
            pres_tail_ticks_reg <= 12'd180;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                owtr_pkg::REG_SHORT:     short_ticks_reg     <= cfg_wdata[7:0];
                owtr_pkg::REG_SLOT:      slot_ticks_reg      <= cfg_wdata;
                owtr_pkg::REG_RST_LOW:   rst_low_ticks_reg   <= cfg_wdata;
                owtr_pkg::REG_PRES_WAIT: pres_wait_ticks_reg <= cfg_wdata;
                owtr_pkg::REG_PRES_TAIL: pres_tail_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Enter operation idx of the sequence
    function automatic owtr_pkg::bus_state_t begin_op(
        input owtr_pkg::bus_state_t st,
        input logic [2:0]           idx,
        input logic [CW-1:0]        short_cfg,
        input logic [CW-1:0]        rst_cfg
    );
        owtr_pkg::bus_state_t s;
        s           = st;
        s.op_index  = idx;
        s.bit_count = '0;
        if (idx == owtr_pkg::OP_RESET_A || idx == owtr_pkg::OP_RESET_B) begin
            s.phase      = owtr_pkg::PH_RST_LOW;
            s.tick_count = owtr_pkg::load_ticks(rst_cfg);
        end else if (idx == owtr_pkg::OP_READ_LO || idx == owtr_pkg::OP_READ_HI) begin
            s.shift_byte = '0;
            s.phase      = owtr_pkg::PH_RD_LOW;
            s.tick_count = owtr_pkg::load_ticks(short_cfg);
        end else begin
            s.shift_byte = owtr_pkg::cmd_byte(idx);
            s.phase      = owtr_pkg::PH_WR_LOW;
            s.tick_count = owtr_pkg::load_ticks(short_cfg);
        end
        return s;
    endfunction

    // One tick of the bus state machine
    always_comb begin
        owtr_pkg::bus_state_t s;
        logic          start, line, drive, done, expire;
        logic [CW-1:0] short_cfg;
        logic [15:0]   raw, mag;
        logic [19:0]   scaled;

        s         = state_reg;
        start     = s_tdata[0];
        line      = s_tdata[1];
        drive     = 1'b0;
        done      = 1'b0;
        short_cfg = CW'(short_ticks_reg);
        raw       = {s.shift_byte, s.low_byte};
        mag       = raw;
        scaled    = '0;

        if (s.phase == owtr_pkg::PH_IDLE && start) begin
            s.held_error = 1'b0;
            s = begin_op(s, owtr_pkg::OP_RESET_A, short_cfg, rst_low_ticks_reg);
        end

        expire = (s.tick_count == '0);
        if (!expire)
            s.tick_count = s.tick_count - TW'(1);

        case (s.phase)
            owtr_pkg::PH_RST_LOW: begin
                drive = 1'b1;
                if (expire) begin
                    s.phase      = owtr_pkg::PH_RST_WAIT;
                    s.tick_count = owtr_pkg::load_ticks(pres_wait_ticks_reg);
                end
            end
            owtr_pkg::PH_RST_WAIT: begin
                if (expire) begin
                    if (line)
                        s.held_error = 1'b1;
                    s.phase      = owtr_pkg::PH_RST_TAIL;
                    s.tick_count = owtr_pkg::load_ticks(pres_tail_ticks_reg);
                end
            end
            owtr_pkg::PH_RST_TAIL: begin
                if (expire) begin
                    if (s.held_error) begin
                        s.held_tenths = '0;
                        s.held_sign   = 1'b0;
                        s.phase       = owtr_pkg::PH_IDLE;
                        done          = 1'b1;
                    end else begin
                        s = begin_op(s, s.op_index + 3'd1, short_cfg, rst_low_ticks_reg);
                    end
                end
            end
            owtr_pkg::PH_WR_LOW: begin
                drive = 1'b1;
                if (expire) begin
                    s.phase      = owtr_pkg::PH_WR_HOLD;
                    s.tick_count = owtr_pkg::load_ticks(slot_ticks_reg);
                end
            end
            owtr_pkg::PH_WR_HOLD: begin
                drive = !s.shift_byte[0];
                if (expire) begin
                    s.phase      = owtr_pkg::PH_WR_REL;
                    s.tick_count = owtr_pkg::load_ticks(short_cfg);
                end
            end
            owtr_pkg::PH_WR_REL: begin
                if (expire) begin
                    s.shift_byte = {1'b0, s.shift_byte[7:1]};
                    if (s.bit_count == 3'd7) begin
                        // write bytes never end the sequence
                        s = begin_op(s, s.op_index + 3'd1, short_cfg, rst_low_ticks_reg);
                    end else begin
                        s.bit_count  = s.bit_count + 3'd1;
                        s.phase      = owtr_pkg::PH_WR_LOW;
                        s.tick_count = owtr_pkg::load_ticks(short_cfg);
                    end
                end
            end
            owtr_pkg::PH_RD_LOW: begin
                drive = 1'b1;
                if (expire) begin
                    s.phase      = owtr_pkg::PH_RD_REL;
                    s.tick_count = owtr_pkg::load_ticks(short_cfg);
                end
            end
            owtr_pkg::PH_RD_REL: begin
                if (expire) begin
                    s.shift_byte = {line, s.shift_byte[7:1]};
                    s.phase      = owtr_pkg::PH_RD_WAIT;
                    s.tick_count = owtr_pkg::load_ticks(slot_ticks_reg);
                end
            end
            owtr_pkg::PH_RD_WAIT: begin
                if (expire) begin
                    if (s.bit_count == 3'd7) begin
                        if (s.op_index == owtr_pkg::OP_READ_HI) begin
                            // sign-magnitude, then tenths = (m*10+8)/16
                            raw = {s.shift_byte, s.low_byte};
                            mag = (raw > owtr_pkg::RAW_POS_LIMIT) ? (16'd0 - raw) : raw;
                            scaled = {mag, 3'b000} + {3'b000, mag, 1'b0} + 20'd8;
                            s.held_sign   = (raw > owtr_pkg::RAW_POS_LIMIT);
                            s.held_tenths = scaled[19:4];
                            s.phase       = owtr_pkg::PH_IDLE;
                            done          = 1'b1;
                        end else begin
                            s.low_byte = s.shift_byte;
                            s = begin_op(s, s.op_index + 3'd1, short_cfg, rst_low_ticks_reg);
                        end
                    end else begin
                        s.bit_count  = s.bit_count + 3'd1;
                        s.phase      = owtr_pkg::PH_RD_LOW;
                        s.tick_count = owtr_pkg::load_ticks(short_cfg);
                    end
                end
            end
            default: begin
                s.phase      = owtr_pkg::PH_IDLE;
                s.tick_count = '0;
            end
        endcase

        state_next    = s;
        out_data_next = {3'b000, s.held_tenths, s.held_sign, s.held_error, done,
                         (s.phase != owtr_pkg::PH_IDLE), drive};
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer)
            out_data_reg <= out_data_next;
    end

    // A finished sequence never reports busy on the same tick
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[2] |-> !out_data_reg[1])
        else $error("done and busy set together");

    // The line is only pulled while a sequence runs
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[0] |-> out_data_reg[1])
        else $error("line driven while idle");

    // Input is held off only by a stalled result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> out_valid_reg && !m_tready)
        else $error("input stalled without output back-pressure");

    // A start in idle enters the reset pulse
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_tdata[0] && state_reg.phase == owtr_pkg::PH_IDLE |=>
            state_reg.phase == owtr_pkg::PH_RST_LOW ||
            state_reg.phase == owtr_pkg::PH_RST_WAIT)
        else $error("start did not begin reset pulse");

endmodule
